FILE: hw/rtl/huffman_tree_load_and_decode_top_assert.svh
// Assertion macros for the Huffman tree load and decode top level.
`ifndef HUFFMAN_TREE_LOAD_AND_DECODE_TOP_ASSERT_SVH
`define HUFFMAN_TREE_LOAD_AND_DECODE_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
// Condition holds at every clock edge outside reset.
`define HTLD_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// Consequent holds at the edge after the antecedent.
`define HTLD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define HTLD_ASSERT_ALWAYS(label, cond, msg)
`define HTLD_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

FILE: hw/rtl/htld_pkg.sv
// Shared types and constants for the Huffman tree load and decode block.
package htld_pkg;

    localparam int SYM_W = 8;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_FINISH = 2'd1,
        OP_DECODE = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_SYMBOL  = 2'd1,
        ST_MISSING = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_CLEAR = 2'd0,
        S_IDLE  = 2'd1,
        S_EXEC  = 2'd2
    } state_t;

endpackage

FILE: hw/rtl/htld_node_mem.sv
// Node store: one synchronous memory word per tree node, with a clearing sweep after reset.
module htld_node_mem #(
    parameter int NODE_COUNT = 512,
    parameter int ENT_W      = 34
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          rd_en,
    input  logic [$clog2(NODE_COUNT)-1:0] rd_addr,
    output logic [ENT_W-1:0]              rd_data,
    input  logic                          wr_en,
    input  logic [$clog2(NODE_COUNT)-1:0] wr_addr,
    input  logic [ENT_W-1:0]              wr_data,
    output logic                          clear_done
);
    import htld_pkg::*;

    localparam int IDX_W = $clog2(NODE_COUNT);

    logic [ENT_W-1:0] mem [NODE_COUNT];
    logic [ENT_W-1:0] rd_data_reg;
    logic [IDX_W-1:0] clear_idx_reg;
    logic [IDX_W-1:0] clear_idx_next;
    logic             clearing_reg;
    logic             clearing_next;

    always_comb
    begin
        clear_idx_next = clear_idx_reg;
        clearing_next  = clearing_reg;
        if (clearing_reg)
        begin
            clear_idx_next = clear_idx_reg + 1'b1;
            if (clear_idx_reg == IDX_W'(NODE_COUNT - 1))
            begin
                clearing_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_idx_reg <= '0;
            clearing_reg  <= 1'b1;
        end
        else
        begin
            clear_idx_reg <= clear_idx_next;
            clearing_reg  <= clearing_next;
        end
    end

    // Sweep zeros through every node before the first transfer is taken.
    always_ff @(posedge clk)
    begin
        if (clearing_reg)
        begin
            mem[clear_idx_reg] <= '0;
        end
        else if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data    = rd_data_reg;
    assign clear_done = !clearing_reg;

endmodule

FILE: hw/rtl/huffman_tree_load_and_decode_top.sv
// Top level: Huffman code tree loader and bit-serial decoder around one node memory.
//
//   channel   handshake             payload
//   input     in_valid / in_ready   operation[1:0], bit_req, symbol[7:0]
//   output    out_valid / out_ready status[1:0], out_symbol[7:0]
//
// On the transfer the node memory read is issued (cursor node, or its parent for a
// finish); in S_EXEC the item is applied, the entry is written back where the item
// changes it and the output register is loaded. Each entry keeps both children and
// both children's symbols, so a decode step needs a single read.
// After reset a clearing sweep over all NODE_COUNT nodes runs before in_ready rises.
// A result left in the output register blocks the next transfer unless taken.
`include "huffman_tree_load_and_decode_top_assert.svh"

module huffman_tree_load_and_decode_top #(
    parameter int NODE_COUNT = 512
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] operation,
    input  logic       bit_req,
    input  logic [7:0] symbol,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] status,
    output logic [7:0] out_symbol
);
    import htld_pkg::*;

    localparam int IDX_W = $clog2(NODE_COUNT);
    localparam int ENT_W = 2 * IDX_W + 2 * SYM_W;

    state_t             state_reg;
    state_t             state_next;
    logic [IDX_W-1:0]   cursor_reg;
    logic [IDX_W-1:0]   cursor_next;
    logic [IDX_W-1:0]   parent_reg;
    logic [IDX_W-1:0]   parent_next;
    logic               pbit_reg;
    logic               pbit_next;
    logic [IDX_W:0]     next_free_reg;
    logic [IDX_W:0]     next_free_next;
    op_t                op_reg;
    logic               bit_reg;
    logic [SYM_W-1:0]   sym_reg;
    logic               out_valid_reg;
    logic               out_valid_next;
    status_t            status_reg;
    status_t            status_next;
    logic [SYM_W-1:0]   out_sym_reg;
    logic [SYM_W-1:0]   out_sym_next;

    logic               accept;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic [ENT_W-1:0]   rd_data;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [ENT_W-1:0]   wr_data;
    logic               clear_done;

    htld_node_mem #(
        .NODE_COUNT (NODE_COUNT),
        .ENT_W      (ENT_W)
    ) u_node_mem (
        .clk        (clk),
        .rst_n      (rst_n),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .clear_done (clear_done)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (clear_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    // Handshake and read port.
    always_comb
    begin
        in_ready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = !out_valid_reg || out_ready;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
        accept  = in_valid && in_ready;
        rd_en   = accept;
        rd_addr = (op_t'(operation) == OP_FINISH) ? parent_reg : cursor_reg;
    end

    // Apply the item to the entry read back from the node memory.
    always_comb
    begin
        logic [IDX_W-1:0] left;
        logic [IDX_W-1:0] right;
        logic [SYM_W-1:0] lsym;
        logic [SYM_W-1:0] rsym;
        logic [IDX_W-1:0] child;
        logic [SYM_W-1:0] csym;

        {left, right, lsym, rsym} = rd_data;
        child = bit_reg ? right : left;
        csym  = bit_reg ? rsym : lsym;

        cursor_next    = cursor_reg;
        parent_next    = parent_reg;
        pbit_next      = pbit_reg;
        next_free_next = next_free_reg;
        status_next    = status_reg;
        out_sym_next   = out_sym_reg;
        out_valid_next = out_valid_reg && !out_ready;
        wr_en          = 1'b0;
        wr_addr        = cursor_reg;
        wr_data        = rd_data;

        if (state_reg == S_EXEC)
        begin
            out_valid_next = 1'b1;
            status_next    = ST_OK;
            out_sym_next   = '0;
            case (op_reg)
                OP_LOAD:
                begin
                    if (child == '0)
                    begin
                        if (next_free_reg < (IDX_W + 1)'(NODE_COUNT))
                        begin
                            // Hook the next free node under the cursor.
                            wr_en = 1'b1;
                            if (bit_reg)
                            begin
                                wr_data = {left, next_free_reg[IDX_W-1:0], lsym, rsym};
                            end
                            else
                            begin
                                wr_data = {next_free_reg[IDX_W-1:0], right, lsym, rsym};
                            end
                            parent_next    = cursor_reg;
                            pbit_next      = bit_reg;
                            cursor_next    = next_free_reg[IDX_W-1:0];
                            next_free_next = next_free_reg + 1'b1;
                        end
                        else
                        begin
                            status_next = ST_FULL;
                            cursor_next = '0;
                        end
                    end
                    else
                    begin
                        parent_next = cursor_reg;
                        pbit_next   = bit_reg;
                        cursor_next = child;
                    end
                end
                OP_FINISH:
                begin
                    // The symbol lives in the parent's slot; the root has none to keep.
                    if (cursor_reg != '0)
                    begin
                        wr_en   = 1'b1;
                        wr_addr = parent_reg;
                        if (pbit_reg)
                        begin
                            wr_data = {left, right, lsym, sym_reg};
                        end
                        else
                        begin
                            wr_data = {left, right, sym_reg, rsym};
                        end
                    end
                    cursor_next = '0;
                end
                OP_DECODE:
                begin
                    if (child == '0)
                    begin
                        status_next = ST_MISSING;
                        cursor_next = '0;
                    end
                    else if (csym != '0)
                    begin
                        status_next  = ST_SYMBOL;
                        out_sym_next = csym;
                        cursor_next  = '0;
                    end
                    else
                    begin
                        parent_next = cursor_reg;
                        pbit_next   = bit_reg;
                        cursor_next = child;
                    end
                end
                default:
                begin
                    status_next = ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            cursor_reg    <= '0;
            parent_reg    <= '0;
            pbit_reg      <= 1'b0;
            next_free_reg <= (IDX_W + 1)'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cursor_reg    <= cursor_next;
            parent_reg    <= parent_next;
            pbit_reg      <= pbit_next;
            next_free_reg <= next_free_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= op_t'(operation);
            bit_reg <= bit_req;
            sym_reg <= symbol;
        end
        status_reg  <= status_next;
        out_sym_reg <= out_sym_next;
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign out_symbol = out_sym_reg;

    `HTLD_ASSERT_ALWAYS(a_cursor_allocated, {1'b0, cursor_reg} < next_free_reg, "cursor beyond allocated nodes")
    `HTLD_ASSERT_ALWAYS(a_free_bound, next_free_reg <= (IDX_W + 1)'(NODE_COUNT), "free pointer overran store")
    `HTLD_ASSERT_NEXT(a_accept_exec, accept, state_reg == S_EXEC, "transfer did not start execution")
    `HTLD_ASSERT_NEXT(a_exec_result, state_reg == S_EXEC, out_valid_reg, "execution produced no result")
    `HTLD_ASSERT_ALWAYS(a_symbol_code, !out_valid_reg || ((status_reg == ST_SYMBOL) == (out_sym_reg != '0)), "symbol field disagrees with status")

endmodule
